// ----- hdl/hexc_pkg.sv -----
// hexc_pkg: types, action codes and helper functions for the hexagonal cube
// coordinate unit. No dependencies; used by the unit, hexc_checker and testbench.
`default_nettype none

package hexc_pkg;

    // Coordinate widths
    localparam int COORD_WIDTH = 32;
    localparam int IN_W        = 32;
    localparam int RES_W       = 36;
    // Internal working width: holds every linear combination and its normal form
    localparam int NW          = COORD_WIDTH + 4;

    // Exact divide by 7: 2-adic inverse built from shift-add doubling steps
    localparam int DIV_STEPS   = $clog2((NW + 2) / 3);
    // Residue mod 7 via 6-bit chunk sum (64 = 1 mod 7)
    localparam int CHUNKS      = (NW + 5) / 6;
    localparam int PAD_W       = CHUNKS * 6;
    localparam int SUM_W       = 6 + $clog2(CHUNKS);
    // Residue mod 7 of the chunk sum via 3-bit digit folds (8 = 1 mod 7)
    localparam int FOLD_DIG    = (SUM_W + 2) / 3;
    localparam int FOLD_W      = FOLD_DIG * 3;

    typedef logic signed [NW-1:0]    coord_t;
    typedef logic signed [RES_W-1:0] res_coord_t;
    typedef logic [2:0]              digit_t;
    typedef logic [3:0]              action_t;

    // Action codes
    localparam action_t ACT_NORM    = 4'd0;
    localparam action_t ACT_UP7     = 4'd1;
    localparam action_t ACT_UP7R    = 4'd2;
    localparam action_t ACT_DOWN7   = 4'd3;
    localparam action_t ACT_DOWN7R  = 4'd4;
    localparam action_t ACT_NEIGH   = 4'd5;
    localparam action_t ACT_ROTCCW  = 4'd6;
    localparam action_t ACT_ROTCW   = 4'd7;
    localparam action_t ACT_TODIGIT = 4'd8;
    localparam action_t ACT_DIGCCW  = 4'd9;
    localparam action_t ACT_DIGCW   = 4'd10;

    // Direction digits
    localparam digit_t DIG_CENTER  = 3'd0;
    localparam digit_t DIG_K       = 3'd1;
    localparam digit_t DIG_J       = 3'd2;
    localparam digit_t DIG_JK      = 3'd3;
    localparam digit_t DIG_I       = 3'd4;
    localparam digit_t DIG_IK      = 3'd5;
    localparam digit_t DIG_IJ      = 3'd6;
    localparam digit_t DIG_INVALID = 3'd7;

    // Input transfer
    typedef struct packed {
        action_t                action;
        logic signed [IN_W-1:0] coord_i;
        logic signed [IN_W-1:0] coord_j;
        logic signed [IN_W-1:0] coord_k;
        digit_t                 in_digit;
    } hexc_in_t;

    // Result transfer
    typedef struct packed {
        res_coord_t res_i;
        res_coord_t res_j;
        res_coord_t res_k;
        digit_t     res_digit;
    } hexc_out_t;

    // Pipeline stage contents
    typedef struct packed {
        action_t    action;
        digit_t     digit;
        logic       norm;   // normalise at the end
        logic       div;    // c0/c1 are rounded through divide by 7
        logic [1:0] neg;    // sign of the c0/c1 numerators
        coord_t     c0;
        coord_t     c1;
        coord_t     c2;
    } pipe_t;

    // Low COORD_WIDTH bits of the raw input, sign-extended
    function automatic coord_t sext_coord(input logic [IN_W-1:0] raw);
        logic [NW-1:0] v;
        v = NW'(raw);
        for (int b = COORD_WIDTH; b < NW; b++)
        begin
            v[b] = v[COORD_WIDTH-1];
        end
        return v;
    endfunction

    function automatic coord_t times3(input coord_t x);
        return (x <<< 1) + x;
    endfunction

    function automatic coord_t times2(input coord_t x);
        return x <<< 1;
    endfunction

    // Sum of 6-bit chunks; same residue mod 7 as the input
    function automatic logic [SUM_W-1:0] chunk_sum(input logic [NW-1:0] x);
        logic [PAD_W-1:0] pad;
        logic [SUM_W-1:0] acc;
        pad = PAD_W'(x);
        acc = '0;
        for (int c = 0; c < CHUNKS; c++)
        begin
            acc = acc + SUM_W'(pad[c*6 +: 6]);
        end
        return acc;
    endfunction

    // Residue mod 7 of a narrow value: three digit folds, then one correction
    function automatic logic [2:0] mod7_small(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0]  v;
        logic [FOLD_W-1:0] pad;
        logic [SUM_W-1:0]  acc;
        v = x;
        for (int f = 0; f < 3; f++)
        begin
            pad = FOLD_W'(v);
            acc = '0;
            for (int d = 0; d < FOLD_DIG; d++)
            begin
                acc = acc + SUM_W'(pad[d*3 +: 3]);
            end
            v = acc;
        end
        if (v >= SUM_W'(7))
        begin
            v = v - SUM_W'(7);
        end
        return v[2:0];
    endfunction

    // 60-degree digit rotations
    function automatic digit_t rot_ccw(input digit_t d);
        digit_t r;
        case (d)
            DIG_K:   r = DIG_IK;
            DIG_J:   r = DIG_JK;
            DIG_JK:  r = DIG_K;
            DIG_I:   r = DIG_IJ;
            DIG_IK:  r = DIG_I;
            DIG_IJ:  r = DIG_J;
            default: r = d;
        endcase
        return r;
    endfunction

    function automatic digit_t rot_cw(input digit_t d);
        digit_t r;
        case (d)
            DIG_K:   r = DIG_JK;
            DIG_J:   r = DIG_IJ;
            DIG_JK:  r = DIG_J;
            DIG_I:   r = DIG_IK;
            DIG_IK:  r = DIG_K;
            DIG_IJ:  r = DIG_I;
            default: r = d;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/hex_cube_coordinate_unit.sv -----
// hex_cube_coordinate_unit: pipelined operations on hexagonal cube coordinates.
// Depends on hexc_pkg (types, action codes, mod-7 and digit helpers).
`default_nettype none

// One transfer is taken on every clock edge where start is high; busy is never
// raised, so items can follow back to back at one per cycle. Each item gives
// exactly one result, shown on result for one cycle with done high. The
// pipeline depth is set by the exact round-to-nearest divide by 7 used by
// the aperture-7 coarsen actions: a mod-7 residue over two stages followed
// by four registered shift-add steps; every action runs through the same
// stages so results leave in input order. The result port cannot be
// stalled; the receiver must take each result in the cycle done is high.
module hex_cube_coordinate_unit
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  hexc_pkg::hexc_in_t      operand,
    output logic                    done,
    output hexc_pkg::hexc_out_t     result
);

    // Stage positions in the valid chain
    localparam int S_IN     = 0;
    localparam int S_LIN    = 1;
    localparam int S_MAG    = 2;
    localparam int S_SUM    = 3;
    localparam int S_REM    = 4;
    localparam int S_STEP0  = 5;
    localparam int S_SIGN   = S_STEP0 + hexc_pkg::DIV_STEPS;
    localparam int S_MIN    = S_SIGN + 1;
    localparam int S_NORM   = S_MIN + 1;
    localparam int S_OUT    = S_NORM + 1;
    localparam int N_STAGES = S_OUT + 1;

    logic [N_STAGES-1:0]        vld_reg;
    logic [N_STAGES-1:0]        vld_next;

    hexc_pkg::pipe_t            in_reg,   in_next;
    hexc_pkg::pipe_t            lin_reg,  lin_next;
    hexc_pkg::pipe_t            mag_reg,  mag_next;
    hexc_pkg::pipe_t            sum_reg;
    logic [hexc_pkg::SUM_W-1:0] sum0_reg, sum1_reg;
    hexc_pkg::pipe_t            div_reg [hexc_pkg::DIV_STEPS+1];
    hexc_pkg::pipe_t            rem_next;
    hexc_pkg::pipe_t            sign_reg, sign_next;
    hexc_pkg::pipe_t            min_reg;
    hexc_pkg::coord_t           minv_reg, minv_next;
    hexc_pkg::pipe_t            norm_reg, norm_next;
    hexc_pkg::hexc_out_t        result_reg, result_next;

    hexc_pkg::coord_t           ci, cj, ck;
    logic [hexc_pkg::NW-1:0]    mag0, mag1;

    // Never stalls
    assign busy = 1'b0;

    // Valid chain
    assign vld_next = {vld_reg[N_STAGES-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Input capture with sign extension
    always_comb
    begin
        in_next        = '0;
        in_next.action = operand.action;
        in_next.digit  = operand.in_digit;
        in_next.c0     = hexc_pkg::sext_coord(operand.coord_i);
        in_next.c1     = hexc_pkg::sext_coord(operand.coord_j);
        in_next.c2     = hexc_pkg::sext_coord(operand.coord_k);
    end

    // Linear combinations per action, digit rotation
    always_comb
    begin
        ci            = in_reg.c0;
        cj            = in_reg.c1;
        ck            = in_reg.c2;
        lin_next      = in_reg;
        lin_next.norm = 1'b1;
        lin_next.div  = 1'b0;
        lin_next.neg  = 2'b00;
        case (in_reg.action)
            hexc_pkg::ACT_UP7:
            begin
                lin_next.c0  = hexc_pkg::times3(ci) - cj - hexc_pkg::times2(ck);
                lin_next.c1  = ci + hexc_pkg::times2(cj) - hexc_pkg::times3(ck);
                lin_next.c2  = '0;
                lin_next.div = 1'b1;
            end
            hexc_pkg::ACT_UP7R:
            begin
                lin_next.c0  = hexc_pkg::times2(ci) + cj - hexc_pkg::times3(ck);
                lin_next.c1  = hexc_pkg::times3(cj) - ci - hexc_pkg::times2(ck);
                lin_next.c2  = '0;
                lin_next.div = 1'b1;
            end
            hexc_pkg::ACT_DOWN7:
            begin
                lin_next.c0 = hexc_pkg::times3(ci) + cj;
                lin_next.c1 = hexc_pkg::times3(cj) + ck;
                lin_next.c2 = ci + hexc_pkg::times3(ck);
            end
            hexc_pkg::ACT_DOWN7R:
            begin
                lin_next.c0 = hexc_pkg::times3(ci) + ck;
                lin_next.c1 = ci + hexc_pkg::times3(cj);
                lin_next.c2 = cj + hexc_pkg::times3(ck);
            end
            hexc_pkg::ACT_NEIGH:
            begin
                if (in_reg.digit == hexc_pkg::DIG_CENTER ||
                    in_reg.digit == hexc_pkg::DIG_INVALID)
                begin
                    lin_next.norm = 1'b0;
                end
                else
                begin
                    // digit bits are the unit vector (i, j, k)
                    lin_next.c0 = ci + hexc_pkg::NW'(in_reg.digit[2]);
                    lin_next.c1 = cj + hexc_pkg::NW'(in_reg.digit[1]);
                    lin_next.c2 = ck + hexc_pkg::NW'(in_reg.digit[0]);
                end
            end
            hexc_pkg::ACT_ROTCCW:
            begin
                lin_next.c0 = ci + ck;
                lin_next.c1 = ci + cj;
                lin_next.c2 = cj + ck;
            end
            hexc_pkg::ACT_ROTCW:
            begin
                lin_next.c0 = ci + cj;
                lin_next.c1 = cj + ck;
                lin_next.c2 = ci + ck;
            end
            hexc_pkg::ACT_DIGCCW:
            begin
                lin_next.digit = hexc_pkg::rot_ccw(in_reg.digit);
            end
            hexc_pkg::ACT_DIGCW:
            begin
                lin_next.digit = hexc_pkg::rot_cw(in_reg.digit);
            end
            default:
            begin
                lin_next.c0 = ci;
            end
        endcase
    end

    // Divide path: sign, magnitude plus 3 (rounding bias)
    always_comb
    begin
        mag_next = lin_reg;
        mag0     = lin_reg.c0[hexc_pkg::NW-1] ? -lin_reg.c0 : lin_reg.c0;
        mag1     = lin_reg.c1[hexc_pkg::NW-1] ? -lin_reg.c1 : lin_reg.c1;
        if (lin_reg.div)
        begin
            mag_next.neg = {lin_reg.c1[hexc_pkg::NW-1], lin_reg.c0[hexc_pkg::NW-1]};
            mag_next.c0  = mag0 + hexc_pkg::NW'(3);
            mag_next.c1  = mag1 + hexc_pkg::NW'(3);
        end
    end

    // Drop the residue so the value is an exact multiple of 7
    always_comb
    begin
        rem_next = sum_reg;
        if (sum_reg.div)
        begin
            rem_next.c0 = sum_reg.c0 - hexc_pkg::NW'(hexc_pkg::mod7_small(sum0_reg));
            rem_next.c1 = sum_reg.c1 - hexc_pkg::NW'(hexc_pkg::mod7_small(sum1_reg));
        end
    end

    // Exact divide: y * (1 + 8 + 64 + ...) by doubling steps, negated later
    for (genvar g = 0; g < hexc_pkg::DIV_STEPS; g++)
    begin : gen_div_step
        localparam int SH = 3 << g;
        hexc_pkg::pipe_t step_next;

        always_comb
        begin
            step_next = div_reg[g];
            if (div_reg[g].div)
            begin
                step_next.c0 = div_reg[g].c0 + (div_reg[g].c0 << SH);
                step_next.c1 = div_reg[g].c1 + (div_reg[g].c1 << SH);
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[g+1] <= step_next;
        end
    end

    // Quotient is minus the series sum; restore the numerator sign
    always_comb
    begin
        sign_next = div_reg[hexc_pkg::DIV_STEPS];
        if (sign_next.div)
        begin
            sign_next.c0 = sign_next.neg[0] ? sign_next.c0 : -sign_next.c0;
            sign_next.c1 = sign_next.neg[1] ? sign_next.c1 : -sign_next.c1;
        end
    end

    // Minimum component
    always_comb
    begin
        minv_next = sign_reg.c0;
        if (sign_reg.c1 < minv_next)
        begin
            minv_next = sign_reg.c1;
        end
        if (sign_reg.c2 < minv_next)
        begin
            minv_next = sign_reg.c2;
        end
    end

    // Plus-normal form
    always_comb
    begin
        norm_next = min_reg;
        if (min_reg.norm)
        begin
            norm_next.c0 = min_reg.c0 - minv_reg;
            norm_next.c1 = min_reg.c1 - minv_reg;
            norm_next.c2 = min_reg.c2 - minv_reg;
        end
    end

    // Result and unit-vector digit match
    always_comb
    begin
        result_next.res_i     = hexc_pkg::RES_W'(norm_reg.c0);
        result_next.res_j     = hexc_pkg::RES_W'(norm_reg.c1);
        result_next.res_k     = hexc_pkg::RES_W'(norm_reg.c2);
        result_next.res_digit = norm_reg.digit;
        if (norm_reg.action == hexc_pkg::ACT_TODIGIT)
        begin
            if (norm_reg.c0[hexc_pkg::NW-1:1] == '0 &&
                norm_reg.c1[hexc_pkg::NW-1:1] == '0 &&
                norm_reg.c2[hexc_pkg::NW-1:1] == '0)
            begin
                result_next.res_digit = {norm_reg.c0[0], norm_reg.c1[0], norm_reg.c2[0]};
            end
            else
            begin
                result_next.res_digit = hexc_pkg::DIG_INVALID;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        lin_reg    <= lin_next;
        mag_reg    <= mag_next;
        sum_reg    <= mag_reg;
        sum0_reg   <= hexc_pkg::chunk_sum(mag_reg.c0);
        sum1_reg   <= hexc_pkg::chunk_sum(mag_reg.c1);
        div_reg[0] <= rem_next;
        sign_reg   <= sign_next;
        min_reg    <= sign_reg;
        minv_reg   <= minv_next;
        norm_reg   <= norm_next;
        result_reg <= result_next;
    end

    assign done   = vld_reg[S_OUT];
    assign result = result_reg;

    // Every accepted transfer gives its result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(N_STAGES) done)
        else $error("result strobe missing after fixed latency");

    // Normalised coordinates are non-negative with at least one zero component
    a_plus_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[S_NORM] && norm_reg.norm) |->
            (!norm_reg.c0[hexc_pkg::NW-1] && !norm_reg.c1[hexc_pkg::NW-1] &&
             !norm_reg.c2[hexc_pkg::NW-1] &&
             (norm_reg.c0 == '0 || norm_reg.c1 == '0 || norm_reg.c2 == '0)))
        else $error("normalised coordinate not in plus-normal form");

endmodule

`default_nettype wire

// ----- sim/hexc_checker.sv -----
// hexc_checker: scoreboard for the hexagonal cube coordinate unit. Watches the
// command and result channels, predicts every result and compares it field by field.
// Depends on hexc_pkg for the transfer types, action codes and direction digits.
module hexc_checker
    import hexc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  hexc_in_t  operand,
    input  logic      done,
    input  hexc_out_t result,
    output int        fail_count,
    output int        pending
);

    // Highest input bit that carries the sign of a coordinate
    localparam int SIGN_BIT = (COORD_WIDTH <= IN_W) ? COORD_WIDTH - 1 : IN_W - 1;

    typedef struct {
        int        seq;
        hexc_out_t coords;
    } awaited_t;

    awaited_t awaited_results[$];
    int       errors      = 0;
    int       outstanding = 0;
    int       accepted    = 0;

    assign fail_count = errors;
    assign pending    = outstanding;

    // One line per mismatch, and count it
    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    // Low COORD_WIDTH bits of a raw component, sign-extended to 64 bits
    function automatic longint widen(input logic [IN_W-1:0] raw);
        longint v;
        logic   sign;
        sign = (COORD_WIDTH <= IN_W) ? raw[SIGN_BIT] : 1'b0;
        for (int b = 0; b < 64; b++)
        begin
            if (b < COORD_WIDTH && b < IN_W)
                v[b] = raw[b];
            else if (b < COORD_WIDTH)
                v[b] = 1'b0;
            else
                v[b] = sign;
        end
        return v;
    endfunction

    // n/7 rounded to nearest, halves away from zero (never met, 7 being odd)
    function automatic longint div7_nearest(input longint n);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q   = (mag + 3) / 7;
        return (n < 0) ? -q : q;
    endfunction

    // 60-degree digit turn; centre and invalid stay put
    function automatic digit_t turn_digit(input digit_t d, input logic ccw);
        digit_t r;
        case (d)
            DIG_K:   r = ccw ? DIG_IK : DIG_JK;
            DIG_J:   r = ccw ? DIG_JK : DIG_IJ;
            DIG_JK:  r = ccw ? DIG_K  : DIG_J;
            DIG_I:   r = ccw ? DIG_IJ : DIG_IK;
            DIG_IK:  r = ccw ? DIG_I  : DIG_K;
            DIG_IJ:  r = ccw ? DIG_J  : DIG_I;
            default: r = d;
        endcase
        return r;
    endfunction

    // Expected result of one command
    function automatic hexc_out_t hex_transform(input hexc_in_t op);
        longint    vi, vj, vk;
        longint    ci, cj, ck;
        longint    a, b, m;
        digit_t    rd;
        logic      norm;
        hexc_out_t r;
        vi   = widen(op.coord_i);
        vj   = widen(op.coord_j);
        vk   = widen(op.coord_k);
        ci   = vi;
        cj   = vj;
        ck   = vk;
        rd   = op.in_digit;
        norm = 1'b1;
        case (op.action)
            ACT_UP7, ACT_UP7R:
            begin
                a = vi - vk;
                b = vj - vk;
                if (op.action == ACT_UP7)
                begin
                    ci = div7_nearest(3 * a - b);
                    cj = div7_nearest(a + 2 * b);
                end
                else
                begin
                    ci = div7_nearest(2 * a + b);
                    cj = div7_nearest(3 * b - a);
                end
                ck = 0;
            end
            ACT_DOWN7:
            begin
                ci = 3 * vi + vj;
                cj = 3 * vj + vk;
                ck = vi + 3 * vk;
            end
            ACT_DOWN7R:
            begin
                ci = 3 * vi + vk;
                cj = vi + 3 * vj;
                ck = vj + 3 * vk;
            end
            ACT_NEIGH:
            begin
                // digit bits are the (i,j,k) unit vector; centre/invalid pass through raw
                if (op.in_digit != DIG_CENTER && op.in_digit != DIG_INVALID)
                begin
                    ci = ci + op.in_digit[2];
                    cj = cj + op.in_digit[1];
                    ck = ck + op.in_digit[0];
                end
                else
                    norm = 1'b0;
            end
            ACT_ROTCCW:
            begin
                ci = vi + vk;
                cj = vi + vj;
                ck = vj + vk;
            end
            ACT_ROTCW:
            begin
                ci = vi + vj;
                cj = vj + vk;
                ck = vi + vk;
            end
            ACT_DIGCCW: rd = turn_digit(op.in_digit, 1'b1);
            ACT_DIGCW:  rd = turn_digit(op.in_digit, 1'b0);
            default:    ;
        endcase

        // Plus-normal form: subtract the smallest component
        if (norm)
        begin
            m = ci;
            if (cj < m)
                m = cj;
            if (ck < m)
                m = ck;
            ci = ci - m;
            cj = cj - m;
            ck = ck - m;
        end

        // Unit vector back to a digit; anything else is invalid
        if (op.action == ACT_TODIGIT)
        begin
            if ((ci == 0 || ci == 1) && (cj == 0 || cj == 1) && (ck == 0 || ck == 1)
                && !(ci == 1 && cj == 1 && ck == 1))
                rd = digit_t'({ci[0], cj[0], ck[0]});
            else
                rd = DIG_INVALID;
        end

        r.res_i     = res_coord_t'(ci);
        r.res_j     = res_coord_t'(cj);
        r.res_k     = res_coord_t'(ck);
        r.res_digit = rd;
        return r;
    endfunction

    // Retire results against the oldest expectation, then log new commands
    always @(posedge clk or negedge rst_n)
    begin
        awaited_t want;
        awaited_t entry;
        if (!rst_n)
        begin
            awaited_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                    flag_error("result transfer with no command outstanding");
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.res_i !== want.coords.res_i)
                        flag_error($sformatf("item %0d res_i: got %0d, want %0d",
                                             want.seq, result.res_i, want.coords.res_i));
                    if (result.res_j !== want.coords.res_j)
                        flag_error($sformatf("item %0d res_j: got %0d, want %0d",
                                             want.seq, result.res_j, want.coords.res_j));
                    if (result.res_k !== want.coords.res_k)
                        flag_error($sformatf("item %0d res_k: got %0d, want %0d",
                                             want.seq, result.res_k, want.coords.res_k));
                    if (result.res_digit !== want.coords.res_digit)
                        flag_error($sformatf("item %0d res_digit: got %0d, want %0d",
                                             want.seq, result.res_digit,
                                             want.coords.res_digit));
                end
            end
            if (start && !busy)
            begin
                entry.seq    = accepted;
                entry.coords = hex_transform(operand);
                awaited_results.push_back(entry);
                accepted++;
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
// testbench: stimulus and verdict for hex_cube_coordinate_unit.
// Depends on hexc_pkg, the unit itself and hexc_checker, which does all checking.
module testbench;
    import hexc_pkg::*;

    localparam int          RANDOM_ITEMS = 1950;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 20;

    localparam logic signed [IN_W-1:0] CMAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] CMIN = {1'b1, {(IN_W-1){1'b0}}};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    hexc_in_t    operand;
    logic        done;
    hexc_out_t   result;
    int          fail_count;
    int          pending;
    int unsigned cycles = 0;
    int          idle_mode;

    hex_cube_coordinate_unit uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .done    (done),
        .result  (result)
    );

    hexc_checker scoreboard
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operand    (operand),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock, period 2
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Idle gap, then hold the command until the transfer is taken
    task automatic send_item(input hexc_in_t item, input int gap);
        for (int n = 0; n < gap; n++)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        operand <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_directed(input action_t act, input logic signed [IN_W-1:0] ci,
                                 input logic signed [IN_W-1:0] cj,
                                 input logic signed [IN_W-1:0] ck, input digit_t d);
        hexc_in_t item;
        item.action   = act;
        item.coord_i  = ci;
        item.coord_j  = cj;
        item.coord_k  = ck;
        item.in_digit = d;
        send_item(item, 0);
    endtask

    // Hold start low until every outstanding result has come back
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [IN_W-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0:       return CMAX;
            1:       return CMIN;
            2:       return CMAX - 1;
            3:       return CMIN + 1;
            4:       return -1;
            5:       return 1;
            default: return 0;
        endcase
    endfunction

    // Random command: wide, small, near-unit (for digit matches) or extreme coordinates
    function automatic hexc_in_t random_item();
        hexc_in_t                 item;
        logic signed [IN_W-1:0]   base;
        digit_t                   d;
        if ($urandom_range(0, 19) == 0)
            item.action = action_t'($urandom_range(ACT_DIGCW + 1, 15));
        else
            item.action = action_t'($urandom_range(ACT_NORM, ACT_DIGCW));
        item.in_digit = digit_t'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0:
            begin
                item.coord_i = $urandom;
                item.coord_j = $urandom;
                item.coord_k = $urandom;
            end
            1:
            begin
                item.coord_i = $urandom_range(0, 16) - 8;
                item.coord_j = $urandom_range(0, 16) - 8;
                item.coord_k = $urandom_range(0, 16) - 8;
            end
            2:
            begin
                base         = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 40) - 20;
                d            = digit_t'($urandom_range(0, 7));
                item.coord_i = base + d[2];
                item.coord_j = base + d[1];
                item.coord_k = base + d[0];
            end
            default:
            begin
                item.coord_i = pick_extreme();
                item.coord_j = pick_extreme();
                item.coord_k = pick_extreme();
            end
        endcase
        return item;
    endfunction

    function automatic int draw_gap();
        case (idle_mode)
            0:       return 0;
            1:       return $urandom_range(0, 14);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        endcase
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        operand   = '0;
        idle_mode = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every action, the special cases
        send_directed(ACT_NORM,    CMAX, CMIN, 0,    DIG_CENTER);
        send_directed(ACT_NORM,    CMIN, CMIN, CMIN, DIG_INVALID);
        send_directed(ACT_UP7,     CMAX, CMIN, CMIN, DIG_IJ);
        send_directed(ACT_UP7,     CMIN, CMAX, CMAX, DIG_K);
        send_directed(ACT_UP7R,    CMAX, 0,    CMIN, DIG_J);
        send_directed(ACT_UP7R,    3,    0,    0,    DIG_JK);
        send_directed(ACT_UP7,     4,    0,    0,    DIG_I);
        send_directed(ACT_DOWN7,   CMAX, CMAX, CMIN, DIG_IK);
        send_directed(ACT_DOWN7R,  CMIN, CMAX, CMAX, DIG_CENTER);
        // neighbour step with centre or invalid digit passes the coordinate through raw
        send_directed(ACT_NEIGH,   5,    -3,   7,    DIG_CENTER);
        send_directed(ACT_NEIGH,   CMIN, CMAX, -1,   DIG_INVALID);
        send_directed(ACT_NEIGH,   CMAX, CMAX, CMAX, DIG_IJ);
        send_directed(ACT_ROTCCW,  CMAX, CMIN, 1,    DIG_K);
        send_directed(ACT_ROTCW,   CMIN, CMAX, CMAX, DIG_J);
        // to-digit: unit vector, centre, and no match
        send_directed(ACT_TODIGIT, 7,    7,    8,    DIG_CENTER);
        send_directed(ACT_TODIGIT, 0,    0,    0,    DIG_IJ);
        send_directed(ACT_TODIGIT, 2,    0,    0,    DIG_K);
        send_directed(ACT_TODIGIT, CMAX, CMAX, CMAX - 1, DIG_INVALID);
        // digit turns, centre and invalid unchanged
        send_directed(ACT_DIGCCW,  1,    2,    3,    DIG_CENTER);
        send_directed(ACT_DIGCCW,  CMIN, 0,    CMAX, DIG_INVALID);
        send_directed(ACT_DIGCCW,  0,    0,    0,    DIG_JK);
        send_directed(ACT_DIGCW,   -4,   -4,   -4,   DIG_INVALID);
        send_directed(ACT_DIGCW,   9,    -9,   0,    DIG_IK);
        // unused action codes behave as norm
        send_directed(action_t'(ACT_DIGCW + 1), CMAX, -1, 6, DIG_I);
        send_directed(action_t'(15), CMIN, 1, -6, DIG_INVALID);
        drain_results();

        // Random traffic in stretches of differing idle behaviour
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                idle_mode = $urandom_range(0, 2);
                if (n % 600 == 300)
                    drain_results();
            end
            send_item(random_item(), draw_gap());
        end

        // Let the pipeline empty out
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
